// ----- rtl/jsce_pkg.sv -----
// Shared types and opcode constants for the JTAG shift command engine.
package jsce_pkg;

	typedef struct packed {
		logic [7:0] host_byte;
		logic [7:0] tdo_samples;
	} jsce_in_t;

	typedef struct packed {
		logic       kind;
		logic       tdi_level;
		logic       tms_level;
		logic [7:0] reply_byte;
		logic       last;
	} jsce_out_t;

	// Command flag bit positions
	localparam int unsigned CMD_INSTR_BIT = 7;
	localparam int unsigned CMD_TMS_BIT   = 6;
	localparam int unsigned CMD_READ_BIT  = 5;
	localparam int unsigned CMD_LSB_BIT   = 3;
	localparam int unsigned CMD_BITS_BIT  = 1;

	localparam logic KIND_PULSE = 1'b0;
	localparam logic KIND_REPLY = 1'b1;

	localparam logic [7:0] REPLY_BAD_CMD = 8'hFA;
	localparam logic [7:0] REPLY_ZERO    = 8'h00;

	// Instruction opcodes
	localparam logic [7:0] OP_SET_LOW     = 8'h80;
	localparam logic [7:0] OP_READ_LOW    = 8'h81;
	localparam logic [7:0] OP_SET_HIGH    = 8'h82;
	localparam logic [7:0] OP_READ_HIGH   = 8'h83;
	localparam logic [7:0] OP_LOOP_ON     = 8'h84;
	localparam logic [7:0] OP_LOOP_OFF    = 8'h85;
	localparam logic [7:0] OP_CLK_DIV     = 8'h86;
	localparam logic [7:0] OP_SEND_IMM    = 8'h87;
	localparam logic [7:0] OP_WAIT_H      = 8'h88;
	localparam logic [7:0] OP_WAIT_L      = 8'h89;
	localparam logic [7:0] OP_DIV5_OFF    = 8'h8A;
	localparam logic [7:0] OP_DIV5_ON     = 8'h8B;
	localparam logic [7:0] OP_3PH_ON      = 8'h8C;
	localparam logic [7:0] OP_3PH_OFF     = 8'h8D;
	localparam logic [7:0] OP_CLK_BITS    = 8'h8E;
	localparam logic [7:0] OP_CLK_BYTES   = 8'h8F;
	localparam logic [7:0] OP_CLK_WAIT_H  = 8'h94;
	localparam logic [7:0] OP_CLK_WAIT_L  = 8'h95;
	localparam logic [7:0] OP_ADAPT_ON    = 8'h96;
	localparam logic [7:0] OP_ADAPT_OFF   = 8'h97;
	localparam logic [7:0] OP_CLK_BYTES_H = 8'h9C;
	localparam logic [7:0] OP_CLK_BYTES_L = 8'h9D;

endpackage

// ----- rtl/jtag_shift_command_engine.sv -----
// JTAG shift command engine: host command byte interpreter with a serial pulse sequencer.
// Results are registered; no new byte is taken until the sequencer is idle again.
// A data byte gives N pulses (N up to 8) and, with the read flag, a capture reply; opcode,
// length and skipped bytes give none; pin reads a zero reply; unknown FA and the opcode.
// One pulse per cycle from the shared shift/capture unit while the output register is free.
// Reset (arst_n low, asynchronous): idle awaiting an opcode, pins low, no result pending.
module jtag_shift_command_engine
	import jsce_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  jsce_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output jsce_out_t out_data
);

	typedef enum logic [2:0] {
		PH_IDLE, PH_LEN_LO, PH_LEN_HI, PH_SHIFT_BYTE, PH_SHIFT_BITS, PH_SKIP
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PULSE, ST_CAPT, ST_ZERO, ST_BAD, ST_OPCODE
	} seq_t;

	phase_t     phase_q;
	seq_t       st_q;
	logic [7:0] cmd_q;
	logic [15:0] len_q;
	logic [1:0] skip_q;
	logic       tdi_pin_q;
	logic       tms_pin_q;
	logic [7:0] data_q;
	logic [7:0] samp_q;
	logic [7:0] cap_q;
	logic [3:0] cnt_q;
	logic [2:0] k_q;
	logic       on_tms_q;
	logic       out_valid_q;
	jsce_out_t  out_q;

	logic       accept;
	logic       out_free;
	logic       out_load;
	logic       lsb;
	logic       rd;
	logic       pulse_bit;
	logic       nxt_tdi;
	logic       nxt_tms;
	logic [2:0] cap_idx;
	logic       cnt_last;
	logic [1:0] skip_dec;

	assign in_ready  = (st_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = out_free && (st_q == ST_PULSE || st_q == ST_CAPT || st_q == ST_ZERO ||
		st_q == ST_BAD || st_q == ST_OPCODE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		lsb       = cmd_q[CMD_LSB_BIT];
		rd        = cmd_q[CMD_READ_BIT];
		pulse_bit = lsb ? data_q[0] : data_q[7];
		nxt_tdi   = on_tms_q ? tdi_pin_q : pulse_bit;
		nxt_tms   = on_tms_q ? pulse_bit : tms_pin_q;
		cap_idx   = lsb ? k_q : ~k_q;
		cnt_last  = (cnt_q == 4'd1);
		skip_dec  = (skip_q != 2'd0) ? skip_q - 2'd1 : skip_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			st_q        <= ST_IDLE;
			cmd_q       <= '0;
			len_q       <= '0;
			skip_q      <= '0;
			tdi_pin_q   <= 1'b0;
			tms_pin_q   <= 1'b0;
			data_q      <= '0;
			samp_q      <= '0;
			cap_q       <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			on_tms_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_ready && !out_load)
				out_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						case (phase_q)
							PH_LEN_LO: begin
								len_q   <= {8'h00, in_data.host_byte};
								phase_q <= cmd_q[CMD_BITS_BIT] ? PH_SHIFT_BITS : PH_LEN_HI;
							end
							PH_LEN_HI: begin
								len_q[15:8] <= in_data.host_byte;
								phase_q     <= PH_SHIFT_BYTE;
							end
							PH_SHIFT_BYTE: begin
								data_q   <= in_data.host_byte;
								samp_q   <= in_data.tdo_samples;
								cap_q    <= '0;
								cnt_q    <= 4'd8;
								k_q      <= '0;
								on_tms_q <= 1'b0;
								st_q     <= ST_PULSE;
								if (len_q != 16'd0)
									len_q <= len_q - 16'd1;
								else
									phase_q <= PH_IDLE;
							end
							PH_SHIFT_BITS: begin
								data_q   <= in_data.host_byte;
								samp_q   <= in_data.tdo_samples;
								cap_q    <= '0;
								cnt_q    <= {1'b0, len_q[2:0]} + 4'd1;
								k_q      <= '0;
								on_tms_q <= cmd_q[CMD_TMS_BIT];
								// TMS shifts hold TDI at data bit 7
								if (cmd_q[CMD_TMS_BIT])
									tdi_pin_q <= in_data.host_byte[7];
								st_q     <= ST_PULSE;
								phase_q  <= PH_IDLE;
							end
							PH_SKIP: begin
								skip_q <= skip_dec;
								if (skip_dec == 2'd0)
									phase_q <= PH_IDLE;
							end
							default: begin
								cmd_q   <= in_data.host_byte;
								if (!in_data.host_byte[CMD_INSTR_BIT]) begin
									phase_q <= PH_LEN_LO;
								end else begin
									case (in_data.host_byte)
										OP_SET_LOW, OP_SET_HIGH, OP_CLK_DIV, OP_CLK_BYTES,
										OP_CLK_BYTES_H, OP_CLK_BYTES_L: begin
											skip_q  <= 2'd2;
											phase_q <= PH_SKIP;
										end
										OP_CLK_BITS: begin
											skip_q  <= 2'd1;
											phase_q <= PH_SKIP;
										end
										OP_READ_LOW, OP_READ_HIGH: begin
											st_q    <= ST_ZERO;
											phase_q <= PH_IDLE;
										end
										OP_LOOP_ON, OP_LOOP_OFF, OP_SEND_IMM, OP_WAIT_H,
										OP_WAIT_L, OP_DIV5_OFF, OP_DIV5_ON, OP_3PH_ON,
										OP_3PH_OFF, OP_CLK_WAIT_H, OP_CLK_WAIT_L,
										OP_ADAPT_ON, OP_ADAPT_OFF: begin
											phase_q <= PH_IDLE;
										end
										default: begin
											st_q    <= ST_BAD;
											phase_q <= PH_IDLE;
										end
									endcase
								end
							end
						endcase
					end
				end
				ST_PULSE: begin
					if (out_free) begin
						out_valid_q          <= 1'b1;
						out_q.kind           <= KIND_PULSE;
						out_q.tdi_level      <= nxt_tdi;
						out_q.tms_level      <= nxt_tms;
						out_q.reply_byte     <= '0;
						out_q.last           <= cnt_last && !rd;
						tdi_pin_q            <= nxt_tdi;
						tms_pin_q            <= nxt_tms;
						cap_q[cap_idx]       <= samp_q[0];
						// advance the shifter toward the next bit
						data_q               <= lsb ? {1'b0, data_q[7:1]} : {data_q[6:0], 1'b0};
						samp_q               <= {1'b0, samp_q[7:1]};
						k_q                  <= k_q + 3'd1;
						cnt_q                <= cnt_q - 4'd1;
						if (cnt_last)
							st_q <= rd ? ST_CAPT : ST_IDLE;
					end
				end
				ST_CAPT, ST_ZERO, ST_BAD, ST_OPCODE: begin
					if (out_free) begin
						out_valid_q      <= 1'b1;
						out_q.kind       <= KIND_REPLY;
						out_q.tdi_level  <= 1'b0;
						out_q.tms_level  <= 1'b0;
						out_q.last       <= (st_q != ST_BAD);
						st_q             <= (st_q == ST_BAD) ? ST_OPCODE : ST_IDLE;
						case (st_q)
							ST_CAPT:   out_q.reply_byte <= cap_q;
							ST_BAD:    out_q.reply_byte <= REPLY_BAD_CMD;
							ST_OPCODE: out_q.reply_byte <= cmd_q;
							default:   out_q.reply_byte <= REPLY_ZERO;
						endcase
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_pulse_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_PULSE) |-> (cnt_q != 4'd0))
		else $error("pulse sequencer running with zero count");

	a_capt_needs_read: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CAPT) |-> cmd_q[CMD_READ_BIT])
		else $error("capture reply without read flag");

	a_reply_pins_low: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.kind == KIND_REPLY) |->
		(!out_data.tdi_level && !out_data.tms_level))
		else $error("reply result carries pin levels");

	a_pulse_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.kind == KIND_PULSE) |-> (out_data.reply_byte == 8'h00))
		else $error("pulse result carries reply byte");

	a_bad_then_opcode: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_BAD && out_free) |=> (st_q == ST_OPCODE && out_data.reply_byte == REPLY_BAD_CMD))
		else $error("unknown opcode reply sequence broken");

endmodule
